// ===== src/lgpc_pkg.sv =====
// Shared constants and types of the linear gradient pixel colour block.
package lgpc_pkg;

   localparam int unsigned COORD_W    = 12;
   localparam int unsigned DELTA_W    = 13;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned NUM_CHAN   = 4;
   localparam int unsigned T_W        = 17;
   localparam int unsigned T_ONE      = 65536;
   localparam int unsigned MAX_WIDTH  = 4096;
   localparam int unsigned MAX_HEIGHT = 4096;
   localparam int unsigned NUM_STAGES = 7;
   localparam int unsigned CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X,
      CSR_START_Y,
      CSR_DELTA_X,
      CSR_DELTA_Y,
      CSR_INV_LEN_SQ,
      CSR_COLOR_START,
      CSR_COLOR_END
   } csr_idx_type;

endpackage

// ===== src/lgpc_intf.sv =====
// Handshake interfaces for the pixel, colour and register write channels.
interface lgpc_req_if;
   logic                        valid;
   logic                        ready;
   logic [lgpc_pkg::COORD_W-1:0] pixel_x;
   logic [lgpc_pkg::COORD_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface lgpc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lgpc_pkg::CHAN_W-1:0] red;
   logic [lgpc_pkg::CHAN_W-1:0] green;
   logic [lgpc_pkg::CHAN_W-1:0] blue;
   logic [lgpc_pkg::CHAN_W-1:0] alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   output ready);
endinterface

interface lgpc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lgpc_pkg::CSR_IDX_W-1:0] index;
   logic [lgpc_pkg::WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/linear_gradient_pixel_color.sv =====
// Linear gradient fill: one pixel coordinate in, one interpolated RGBA colour out.
// Each pixel beat passes a seven-stage pipeline (offset, two 13x13 products, dot sum,
// 26x32 scale by the reciprocal squared length, clamp of t, per-channel weight products,
// final sum). A beat's colour is valid on the result channel once it reaches the last stage,
// and leaves when that channel is ready. One pixel is accepted every clock unless a stall
// has filled all stages; the 26x32 multiplier and the blend products each own a stage.
// Every stage has its own valid bit and holds under back-pressure, so a stalled result
// only blocks the pipeline once all stages are full. Registers are written on the csr
// channel, which is always ready; write them only while no pixel is in flight.
module linear_gradient_pixel_color (
   input  logic       clock,
   input  logic       reset,
   lgpc_req_if.sink   req_if,
   lgpc_rsp_if.source rsp_if,
   lgpc_csr_if.sink   csr_if
);
   import lgpc_pkg::*;

   // configuration registers
   logic        [COORD_W-1:0] start_x_ff;
   logic        [COORD_W-1:0] start_y_ff;
   logic signed [DELTA_W-1:0] delta_x_ff;
   logic signed [DELTA_W-1:0] delta_y_ff;
   logic        [WORD_W-1:0]  inv_len_sq_ff;
   logic        [WORD_W-1:0]  color_start_ff;
   logic        [WORD_W-1:0]  color_end_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         delta_x_ff     <= '0;
         delta_y_ff     <= '0;
         inv_len_sq_ff  <= '0;
         color_start_ff <= '0;
         color_end_ff   <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_START_X:     start_x_ff     <= csr_if.data[COORD_W-1:0];
            CSR_START_Y:     start_y_ff     <= csr_if.data[COORD_W-1:0];
            CSR_DELTA_X:     delta_x_ff     <= csr_if.data[DELTA_W-1:0];
            CSR_DELTA_Y:     delta_y_ff     <= csr_if.data[DELTA_W-1:0];
            CSR_INV_LEN_SQ:  inv_len_sq_ff  <= csr_if.data;
            CSR_COLOR_START: color_start_ff <= csr_if.data;
            CSR_COLOR_END:   color_end_ff   <= csr_if.data;
            default: ;
         endcase
      end
   end

   // valid bits and per-stage ready
   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] v_in;
   logic [NUM_STAGES:0]   rdy;

   always_comb begin
      rdy[NUM_STAGES] = rsp_if.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   assign req_if.ready = rdy[0];

   always_comb begin
      v_in = v_ff;
      if (rdy[0]) begin
         v_in[0] = req_if.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (rdy[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 0: clamp to frame and offset from start
   logic        [COORD_W-1:0] px_sat;
   logic        [COORD_W-1:0] py_sat;
   logic signed [DELTA_W-1:0] ox_in, ox_ff;
   logic signed [DELTA_W-1:0] oy_in, oy_ff;

   always_comb begin
      px_sat = ({5'b0, req_if.pixel_x} >= T_W'(MAX_WIDTH)) ?
               COORD_W'(MAX_WIDTH - 1) : req_if.pixel_x;
      py_sat = ({5'b0, req_if.pixel_y} >= T_W'(MAX_HEIGHT)) ?
               COORD_W'(MAX_HEIGHT - 1) : req_if.pixel_y;
      ox_in  = $signed({1'b0, px_sat}) - $signed({1'b0, start_x_ff});
      oy_in  = $signed({1'b0, py_sat}) - $signed({1'b0, start_y_ff});
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
      end
   end

   // stage 1: projection products
   logic signed [2*DELTA_W-1:0] mx_in, mx_ff;
   logic signed [2*DELTA_W-1:0] my_in, my_ff;

   always_comb begin
      mx_in = (2*DELTA_W)'(ox_ff) * (2*DELTA_W)'(delta_x_ff);
      my_in = (2*DELTA_W)'(oy_ff) * (2*DELTA_W)'(delta_y_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
      end
   end

   // stage 2: dot product, negative or zero gives t = 0
   logic signed [2*DELTA_W:0]   dot;
   logic        [2*DELTA_W-1:0] dot_in, dot_ff;

   always_comb begin
      dot    = (2*DELTA_W+1)'(mx_ff) + (2*DELTA_W+1)'(my_ff);
      dot_in = (!dot[2*DELTA_W] && dot != '0) ? dot[2*DELTA_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         dot_ff <= dot_in;
      end
   end

   // stage 3: scale by reciprocal squared length
   localparam int unsigned SCL_W = 2*DELTA_W + WORD_W;
   logic [SCL_W-1:0] scl_in, scl_ff;

   assign scl_in = SCL_W'(dot_ff) * SCL_W'(inv_len_sq_ff);

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         scl_ff <= scl_in;
      end
   end

   // stage 4: t in Q1.16, clamped to one
   logic [T_W-1:0] t_in, t_ff;

   assign t_in = (scl_ff[SCL_W-1:15] > (SCL_W-15)'(T_ONE)) ?
                 T_W'(T_ONE) : scl_ff[T_W+14:15];

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         t_ff <= t_in;
      end
   end

   // stage 5: channel weight products
   localparam int unsigned BP_W = CHAN_W + 16;
   logic [T_W-1:0]  w_start;
   logic [BP_W-1:0] pa_in [NUM_CHAN];
   logic [BP_W-1:0] pb_in [NUM_CHAN];
   logic [BP_W-1:0] pa_ff [NUM_CHAN];
   logic [BP_W-1:0] pb_ff [NUM_CHAN];

   always_comb begin
      w_start = T_W'(T_ONE) - t_ff;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         pa_in[ch] = BP_W'(color_start_ff[WORD_W-1-CHAN_W*ch -: CHAN_W]) * BP_W'(w_start);
         pb_in[ch] = BP_W'(color_end_ff[WORD_W-1-CHAN_W*ch -: CHAN_W]) * BP_W'(t_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
   end

   // stage 6: sum and truncate
   logic [BP_W-1:0]   sum [NUM_CHAN];
   logic [CHAN_W-1:0] chan_in [NUM_CHAN];
   logic [CHAN_W-1:0] chan_ff [NUM_CHAN];

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sum[ch]     = pa_ff[ch] + pb_ff[ch];
         chan_in[ch] = sum[ch][BP_W-1:16];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         chan_ff <= chan_in;
      end
   end

   assign rsp_if.valid = v_ff[NUM_STAGES-1];
   assign rsp_if.red   = chan_ff[0];
   assign rsp_if.green = chan_ff[1];
   assign rsp_if.blue  = chan_ff[2];
   assign rsp_if.alpha = chan_ff[3];

   a_t_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[4] |-> t_ff <= T_W'(T_ONE))
      else $error("t above one");

   a_zero_inv: assert property (@(posedge clock) disable iff (reset)
      v_ff[2] && rdy[3] && inv_len_sq_ff == '0 |=> scl_ff == '0)
      else $error("zero reciprocal gave non-zero scale");

   a_nonpos_dot: assert property (@(posedge clock) disable iff (reset)
      v_ff[1] && rdy[2] && (mx_ff + my_ff) <= 0 && !(mx_ff[2*DELTA_W-1] ^ my_ff[2*DELTA_W-1])
      && mx_ff[2*DELTA_W-1] |=> dot_ff == '0)
      else $error("negative projection passed");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[3] && !rdy[3] |=> v_ff[3] && $stable(scl_ff))
      else $error("stalled stage lost its beat");

endmodule

// ===== tb/linear_gradient_pixel_color_tb.sv =====
// Self-checking testbench for the linear gradient pixel colour block.
module linear_gradient_pixel_color_tb;
   import lgpc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam logic [COORD_W-1:0]   COORD_MAX = COORD_W'(MAX_WIDTH - 1);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } colour_type;

   logic clock;
   logic reset;

   lgpc_req_if req_if();
   lgpc_rsp_if rsp_if();
   lgpc_csr_if csr_if();

   linear_gradient_pixel_color u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // register mirror
   logic [COORD_W-1:0] origin_x     = '0;
   logic [COORD_W-1:0] origin_y     = '0;
   logic [DELTA_W-1:0] span_x       = '0;
   logic [DELTA_W-1:0] span_y       = '0;
   logic [WORD_W-1:0]  recip_len_sq = '0;
   logic [WORD_W-1:0]  colour_from  = '0;
   logic [WORD_W-1:0]  colour_to    = '0;

   colour_type  expected_colours[$];
   int unsigned error_count = 0;
   int unsigned gap_pct     = 0;
   int unsigned stall_pct   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic colour_type predict_colour(input logic [COORD_W-1:0] px,
                                                 input logic [COORD_W-1:0] py);
      longint            dot;
      longint unsigned   frac;
      longint unsigned   mix;
      logic [WORD_W-1:0] word;
      frac = 0;
      dot = (longint'(px) - longint'(origin_x)) * longint'($signed(span_x))
          + (longint'(py) - longint'(origin_y)) * longint'($signed(span_y));
      if (dot > 0) begin
         frac = dot;
         frac = (frac * recip_len_sq) >> 15;
         if (frac > T_ONE)
            frac = T_ONE;
      end
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         mix = colour_from[WORD_W-1-CHAN_W*ch -: CHAN_W] * (T_ONE - frac)
             + colour_to[WORD_W-1-CHAN_W*ch -: CHAN_W] * frac;
         word[WORD_W-1-CHAN_W*ch -: CHAN_W] = mix[CHAN_W+15:16];
      end
      return colour_type'(word);
   endfunction

   // result side: random back-pressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      colour_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_colours.size() == 0) begin
            $error("colour beat with no pixel outstanding");
            error_count++;
         end else begin
            want = expected_colours.pop_front();
            if (rsp_if.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_if.red);
               error_count++;
            end
            if (rsp_if.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_if.green);
               error_count++;
            end
            if (rsp_if.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_if.blue);
               error_count++;
            end
            if (rsp_if.alpha !== want.alpha) begin
               $error("alpha: expected %0d, got %0d", want.alpha, rsp_if.alpha);
               error_count++;
            end
         end
      end
   end

   task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.pixel_x <= px;
      req_if.pixel_y <= py;
      do @(posedge clock); while (!req_if.ready);
      expected_colours.push_back(predict_colour(px, py));
   endtask

   // pipeline empty and settled before any register write
   task automatic wait_for_colours;
      req_if.valid <= 1'b0;
      while (expected_colours.size() != 0)
         @(posedge clock);
      repeat (NUM_STAGES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0]    data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      unique case (idx)
         CSR_START_X:     origin_x     = data[COORD_W-1:0];
         CSR_START_Y:     origin_y     = data[COORD_W-1:0];
         CSR_DELTA_X:     span_x       = data[DELTA_W-1:0];
         CSR_DELTA_Y:     span_y       = data[DELTA_W-1:0];
         CSR_INV_LEN_SQ:  recip_len_sq = data;
         CSR_COLOR_START: colour_from  = data;
         CSR_COLOR_END:   colour_to    = data;
         default: ;
      endcase
   endtask

   // narrow registers get random upper bits, which must be ignored
   task automatic load_gradient(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                input logic [DELTA_W-1:0] dx, input logic [DELTA_W-1:0] dy,
                                input logic [WORD_W-1:0] inv, input logic [WORD_W-1:0] c0,
                                input logic [WORD_W-1:0] c1);
      logic [WORD_W-1:0] word;
      word = $urandom();
      word[COORD_W-1:0] = sx;
      write_register(CSR_START_X, word);
      word = $urandom();
      word[COORD_W-1:0] = sy;
      write_register(CSR_START_Y, word);
      word = $urandom();
      word[DELTA_W-1:0] = dx;
      write_register(CSR_DELTA_X, word);
      word = $urandom();
      word[DELTA_W-1:0] = dy;
      write_register(CSR_DELTA_Y, word);
      write_register(CSR_INV_LEN_SQ, inv);
      write_register(CSR_COLOR_START, c0);
      write_register(CSR_COLOR_END, c1);
      csr_if.valid <= 1'b0;
   endtask

   task automatic randomise_gradient;
      logic [DELTA_W-1:0] dx;
      logic [DELTA_W-1:0] dy;
      logic [WORD_W-1:0]  inv;
      logic [WORD_W-1:0]  c0;
      logic [WORD_W-1:0]  c1;
      longint             len_sq;
      int unsigned        mode;
      mode = $urandom_range(9);
      if ($urandom_range(3) == 0) begin
         dx = DELTA_W'(int'($urandom_range(64)) - 32);
         dy = DELTA_W'(int'($urandom_range(64)) - 32);
      end else begin
         dx = DELTA_W'($urandom());
         dy = DELTA_W'($urandom());
      end
      len_sq = longint'($signed(dx)) * longint'($signed(dx))
             + longint'($signed(dy)) * longint'($signed(dy));
      c0 = $urandom();
      c1 = $urandom();
      case (mode)
         0: inv = '0;
         1: inv = $urandom();
         2: inv = '1;
         default: inv = (len_sq == 0) ? $urandom() : WORD_W'((longint'(1) << 31) / len_sq);
      endcase
      if (mode == 3) begin
         c0 = '0;
         c1 = '1;
      end
      if ($urandom_range(7) == 0)
         write_register(CSR_SPARE, $urandom());
      load_gradient(COORD_W'($urandom()), COORD_W'($urandom()), dx, dy, inv, c0, c1);
   endtask

   task automatic test_reset_state;
      send_pixel(12'd0, 12'd0);
      send_pixel(COORD_MAX, COORD_MAX);
      wait_for_colours();
   endtask

   task automatic test_full_span;
      load_gradient(12'd0, 12'd0, 13'd4095, 13'd0, 32'd128, 32'h00FF80FF, 32'hFF00FF01);
      send_pixel(12'd0, 12'd0);
      send_pixel(COORD_MAX, 12'd0);
      send_pixel(12'd2048, 12'd0);
      send_pixel(12'd1024, COORD_MAX);
      send_pixel(12'd1, 12'd0);
      send_pixel(COORD_MAX, COORD_MAX);
      wait_for_colours();
   endtask

   task automatic test_zero_reciprocal;
      load_gradient(12'd100, 12'd200, 13'd300, -13'd50, 32'd0, 32'h12345678, 32'hFEDCBA98);
      send_pixel(COORD_MAX, 12'd0);
      send_pixel(COORD_MAX, COORD_MAX);
      wait_for_colours();
   endtask

   task automatic test_zero_vector;
      load_gradient(12'd2000, 12'd2000, 13'd0, 13'd0, 32'hFFFFFFFF, 32'hA5A5A5A5,
                    32'h5A5A5A5A);
      send_pixel(12'd0, 12'd0);
      send_pixel(COORD_MAX, COORD_MAX);
      wait_for_colours();
   endtask

   task automatic test_behind_start;
      load_gradient(12'd2048, 12'd2048, 13'd1000, 13'd1000, 32'd1073, 32'h10203040,
                    32'hF0E0D0C0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd2047, 12'd2048);
      send_pixel(12'd2049, 12'd2048);
      wait_for_colours();
   endtask

   task automatic test_register_extremes;
      load_gradient(COORD_MAX, COORD_MAX, 13'h1000, 13'h1000,
                    32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000);
      send_pixel(12'd0, 12'd0);
      send_pixel(COORD_MAX - 12'd1, COORD_MAX);
      send_pixel(COORD_MAX, COORD_MAX);
      wait_for_colours();
      load_gradient(12'd0, 12'd0, 13'd4095, 13'd4095, 32'h80000000, 32'h00000000,
                    32'hFFFFFFFF);
      send_pixel(COORD_MAX, COORD_MAX);
      send_pixel(12'd1, 12'd0);
      wait_for_colours();
      // an index past the register list must change nothing
      write_register(CSR_SPARE, 32'hFFFFFFFF);
      csr_if.valid <= 1'b0;
      send_pixel(12'd2048, 12'd2048);
      wait_for_colours();
   endtask

   task automatic test_random_fill(input int unsigned gap, input int unsigned stall,
                                   input int items, input int pause_at);
      int px;
      int py;
      int f;
      gap_pct   = gap;
      stall_pct = stall;
      for (int n = 0; n < items; n++) begin
         if (n % 100 == 0) begin
            wait_for_colours();
            randomise_gradient();
         end
         if (n == pause_at)
            wait_for_colours();
         if ($urandom_range(1) == 1) begin
            px = $urandom_range(COORD_MAX);
            py = $urandom_range(COORD_MAX);
         end else begin
            // steer pixels along the gradient so t sweeps its whole range
            f  = int'($urandom_range(1200)) - 100;
            px = int'(origin_x) + int'($signed(span_x)) * f / 1024
               + int'($urandom_range(16)) - 8;
            py = int'(origin_y) + int'($signed(span_y)) * f / 1024
               + int'($urandom_range(16)) - 8;
            if (px < 0) px = 0;
            else if (px > int'(COORD_MAX)) px = int'(COORD_MAX);
            if (py < 0) py = 0;
            else if (py > int'(COORD_MAX)) py = int'(COORD_MAX);
         end
         send_pixel(px[COORD_W-1:0], py[COORD_W-1:0]);
      end
      wait_for_colours();
   endtask

   initial begin
      req_if.valid   <= 1'b0;
      req_if.pixel_x <= '0;
      req_if.pixel_y <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= CSR_START_X;
      csr_if.data    <= '0;
      reset          <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_full_span();
      test_zero_reciprocal();
      test_zero_vector();
      test_behind_start();
      test_register_extremes();
      test_random_fill(0, 0, 400, 200);
      test_random_fill(63, 0, 400, -1);
      test_random_fill(0, 63, 400, -1);
      test_random_fill(27, 27, 400, 150);
      test_random_fill(0, 0, 400, -1);

      repeat (4 * NUM_STAGES) @(posedge clock);
      if (error_count == 0 && expected_colours.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== linear_gradient_pixel_color.f =====
src/lgpc_pkg.sv
src/lgpc_intf.sv
src/linear_gradient_pixel_color.sv
tb/linear_gradient_pixel_color_tb.sv
